// ===== src/cubic_trapezoid_integrator_top_macros.svh =====
// Assertion macros shared by the integrator's RTL.
// No dependencies; included by cti_ctrl, which carries concurrent checks.
`ifndef CUBIC_TRAPEZOID_INTEGRATOR_TOP_MACROS_SVH
`define CUBIC_TRAPEZOID_INTEGRATOR_TOP_MACROS_SVH

// same-cycle implication
`define CTI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cti_pkg.sv =====
// Shared types and constants for the cubic trapezoid integrator.
// No dependencies; imported by every module of the block.
package cti_pkg;

   localparam int DATA_W     = 32;
   localparam int WIDE_W     = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CNT_REG_W  = 16;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] REG_COEFF_CUBIC  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_COEFF_SQUARE = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_COEFF_LINEAR = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_COEFF_OFFSET = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SAMPLE_COUNT = 3'd4;

   localparam logic signed [DATA_W-1:0] CUBIC_RESET        = 32'sd65536;
   localparam logic [CNT_REG_W-1:0]     SAMPLE_COUNT_RESET = 16'd8192;

   localparam logic [WIDE_W-1:0] WIDE_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [WIDE_W-1:0] WIDE_MIN   = 64'h8000_0000_0000_0000;
   localparam logic [DATA_W-1:0] NARROW_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] NARROW_MIN = 32'h8000_0000;

   // which product the shared multiplier forms, and where it lands
   typedef enum logic [2:0] {
      MOP_XX,     // x * x        -> x2
      MOP_X2X,    // x2 * x       -> x3
      MOP_C3,     // cubic * x3   -> sum
      MOP_C2,     // square * x2  -> sum +
      MOP_C1,     // linear * x   -> sum +
      MOP_STEP    // f(x) * step  -> sample product
   } mul_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_OFFSET,
      ST_SAMPLE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic       mul_start;
      mul_op_type mul_op;
      logic       add_offset;
      logic       first_sample;
      logic       accum;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic div_done;
      logic mul_done;
      logic last_sample;
   } status_type;

endpackage

// ===== src/cti_mul.sv =====
// Iterative signed 64x64 fixed-point multiplier on one 32x32 unit.
// Depends on cti_pkg; used by cti_dp.
module cti_mul import cti_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WIDE_W-1:0] op_a,
   input  logic signed [WIDE_W-1:0] op_b,
   output logic                     done,
   output logic signed [WIDE_W-1:0] result,
   output logic                     sat
);

   localparam int ACC_W = 2 * WIDE_W;

   logic              busy_ff, busy_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [WIDE_W-1:0] ua_ff, ua_in, ub_ff, ub_in;
   logic              neg_ff, neg_in;
   logic [WIDE_W-1:0] prod_ff, prod_in;
   logic [1:0]        sh_ff, sh_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [WIDE_W-1:0] res_ff, res_in;
   logic              sat_ff, sat_in;
   logic              done_ff, done_in;

   logic [DATA_W-1:0] a_half, b_half;
   logic [ACC_W-1:0]  addend;
   logic [WIDE_W-1:0] m_val, m_lim;
   logic              m_sat;

   always_comb begin
      a_half = cnt_ff[1] ? ua_ff[WIDE_W-1:DATA_W] : ua_ff[DATA_W-1:0];
      b_half = cnt_ff[0] ? ub_ff[WIDE_W-1:DATA_W] : ub_ff[DATA_W-1:0];

      case (sh_ff)
         2'd0:    addend = {{WIDE_W{1'b0}}, prod_ff};
         2'd1:    addend = {{DATA_W{1'b0}}, prod_ff, {DATA_W{1'b0}}};
         2'd2:    addend = {prod_ff, {WIDE_W{1'b0}}};
         default: addend = '0;
      endcase

      // truncate toward zero on the magnitude, then clamp
      m_val = acc_ff[FRAC_BITS +: WIDE_W];
      m_sat = (|acc_ff[ACC_W-1:FRAC_BITS+WIDE_W]) ||
              (m_val[WIDE_W-1] && (!neg_ff || (|m_val[WIDE_W-2:0])));
      m_lim = m_sat ? (neg_ff ? WIDE_MIN : WIDE_MAX) : m_val;

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         ua_in   = op_a[WIDE_W-1] ? WIDE_W'(-op_a) : op_a;
         ub_in   = op_b[WIDE_W-1] ? WIDE_W'(-op_b) : op_b;
         neg_in  = op_a[WIDE_W-1] ^ op_b[WIDE_W-1];
         acc_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff <= 3'd3) begin
            prod_in = a_half * b_half;
            sh_in   = 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
         end
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4) begin
            acc_in = acc_ff + addend;
         end
         if (cnt_ff == 3'd5) begin
            res_in  = neg_ff ? WIDE_W'(-m_lim) : m_lim;
            sat_in  = m_sat;
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      sat_ff  <= sat_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
   assign sat    = sat_ff;

endmodule

// ===== src/cti_div.sv =====
// Restoring divider for the step: signed 33-bit bound difference over count.
// Depends on cti_pkg; used by cti_dp. One quotient bit per cycle.
module cti_div import cti_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W:0]   dividend,
   input  logic [COUNT_BITS-1:0]    divisor,
   output logic                     done,
   output logic signed [DATA_W-1:0] quotient,
   output logic                     sat
);

   localparam int NUM_W = DATA_W + 1;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in, den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [DATA_W-1:0]     q_ff, q_in;
   logic                  sat_ff, sat_in;
   logic                  done_ff, done_in;

   logic [COUNT_BITS:0]   trial;
   logic                  fits;
   logic                  q_sat;
   logic [DATA_W-1:0]     q_lim;

   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      fits  = trial >= {1'b0, den_ff};

      // quotient magnitude is in num_ff once all bits are shifted in
      q_sat = num_ff[NUM_W-1] || (num_ff[DATA_W-1] &&
              (!neg_ff || (|num_ff[DATA_W-2:0])));
      q_lim = q_sat ? (neg_ff ? NARROW_MIN : NARROW_MAX) : num_ff[DATA_W-1:0];

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend[DATA_W] ? NUM_W'(-dividend) : dividend;
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = dividend[DATA_W];
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(NUM_W)) begin
            q_in    = neg_ff ? DATA_W'(-q_lim) : q_lim;
            sat_in  = q_sat;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in = fits ? COUNT_BITS'(trial - {1'b0, den_ff}) : trial[COUNT_BITS-1:0];
            num_in = {num_ff[NUM_W-2:0], fits};
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;
   assign sat      = sat_ff;

endmodule

// ===== src/cti_dp.sv =====
// Datapath: config registers, sample point, polynomial terms, Riemann sums.
// Depends on cti_pkg, cti_mul and cti_div; driven by cti_ctrl commands.
module cti_dp import cti_pkg::*; #(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_W-1:0]    csr_addr,
   input  logic [DATA_W-1:0]        csr_wdata,
   input  logic signed [DATA_W-1:0] req_interval_low,
   input  logic signed [DATA_W-1:0] req_interval_high,
   input  cmd_type                  cmd,
   output status_type               status,
   output logic signed [WIDE_W-1:0] rsp_area,
   output logic                     rsp_overflow
);

   logic signed [DATA_W-1:0] cubic_ff, cubic_in, square_ff, square_in;
   logic signed [DATA_W-1:0] linear_ff, linear_in, offset_ff, offset_in;
   logic [CNT_REG_W-1:0]     count_reg_ff, count_reg_in;

   logic signed [DATA_W:0]   diff_ff, diff_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in, idx_ff, idx_in;
   logic signed [DATA_W-1:0] step_ff, step_in;
   logic signed [WIDE_W-1:0] x_ff, x_in, x2_ff, x2_in, x3_ff, x3_in;
   logic signed [WIDE_W-1:0] s_ff, s_in, ps_ff, ps_in, pl_ff, pl_in;
   logic signed [WIDE_W-1:0] left_ff, left_in, right_ff, right_in;
   logic signed [WIDE_W-1:0] area_ff, area_in;
   logic                     ov_ff, ov_in, ovo_ff, ovo_in;

   logic                     div_done, div_sat;
   logic signed [DATA_W-1:0] div_q;
   logic                     mul_done, mul_sat;
   logic signed [WIDE_W-1:0] mul_a, mul_b, mul_r;

   logic [COUNT_BITS-1:0]    count_eff;
   logic signed [WIDE_W-1:0] step_ext;
   logic [WIDE_W:0]          wb_sum, off_sum, acc_l, acc_r;
   logic signed [WIDE_W:0]   area_sum;

   // saturating add; bit 64 flags a clamp
   function automatic logic [WIDE_W:0] sat_add(input logic signed [WIDE_W-1:0] a,
                                               input logic signed [WIDE_W-1:0] b);
      logic signed [WIDE_W-1:0] s;
      s = a + b;
      if ((a[WIDE_W-1] == b[WIDE_W-1]) && (s[WIDE_W-1] != a[WIDE_W-1])) begin
         sat_add = {1'b1, (a[WIDE_W-1] ? WIDE_MIN : WIDE_MAX)};
      end else begin
         sat_add = {1'b0, s};
      end
   endfunction

   cti_div #(.COUNT_BITS(COUNT_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (diff_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q),
      .sat      (div_sat)
   );

   cti_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_r),
      .sat    (mul_sat)
   );

   always_comb begin
      case (cmd.mul_op)
         MOP_XX: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         MOP_X2X: begin
            mul_a = x2_ff;
            mul_b = x_ff;
         end
         MOP_C3: begin
            mul_a = {{DATA_W{cubic_ff[DATA_W-1]}}, cubic_ff};
            mul_b = x3_ff;
         end
         MOP_C2: begin
            mul_a = {{DATA_W{square_ff[DATA_W-1]}}, square_ff};
            mul_b = x2_ff;
         end
         MOP_C1: begin
            mul_a = {{DATA_W{linear_ff[DATA_W-1]}}, linear_ff};
            mul_b = x_ff;
         end
         MOP_STEP: begin
            mul_a = s_ff;
            mul_b = step_ext;
         end
         default: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
      endcase
   end

   always_comb begin
      count_eff = COUNT_BITS'(count_reg_ff);
      step_ext  = {{DATA_W{step_ff[DATA_W-1]}}, step_ff};
      wb_sum    = sat_add(s_ff, mul_r);
      off_sum   = sat_add(s_ff, {{DATA_W{offset_ff[DATA_W-1]}}, offset_ff});
      acc_l     = sat_add(left_ff, pl_ff);
      acc_r     = sat_add(right_ff, ps_ff);
      // floor of the mean, exact in 65 bits
      area_sum  = {left_ff[WIDE_W-1], left_ff} + {right_ff[WIDE_W-1], right_ff};

      cubic_in     = cubic_ff;
      square_in    = square_ff;
      linear_in    = linear_ff;
      offset_in    = offset_ff;
      count_reg_in = count_reg_ff;
      diff_in      = diff_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      x2_in        = x2_ff;
      x3_in        = x3_ff;
      s_in         = s_ff;
      ps_in        = ps_ff;
      pl_in        = pl_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      area_in      = area_ff;
      ov_in        = ov_ff;
      ovo_in       = ovo_ff;

      if (csr_we) begin
         case (csr_addr)
            REG_COEFF_CUBIC:  cubic_in     = $signed(csr_wdata);
            REG_COEFF_SQUARE: square_in    = $signed(csr_wdata);
            REG_COEFF_LINEAR: linear_in    = $signed(csr_wdata);
            REG_COEFF_OFFSET: offset_in    = $signed(csr_wdata);
            REG_SAMPLE_COUNT: count_reg_in = csr_wdata[CNT_REG_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         diff_in  = {req_interval_high[DATA_W-1], req_interval_high} -
                    {req_interval_low[DATA_W-1], req_interval_low};
         x_in     = {{DATA_W{req_interval_low[DATA_W-1]}}, req_interval_low};
         count_in = count_eff;
         idx_in   = '0;
         left_in  = '0;
         right_in = '0;
         ov_in    = 1'b0;
      end

      if (div_done) begin
         step_in = div_q;
         ov_in   = ov_in | div_sat;
      end

      if (mul_done) begin
         ov_in = ov_in | mul_sat;
         case (cmd.mul_op)
            MOP_XX:   x2_in = mul_r;
            MOP_X2X:  x3_in = mul_r;
            MOP_C3:   s_in  = mul_r;
            MOP_C2, MOP_C1: begin
               s_in  = wb_sum[WIDE_W-1:0];
               ov_in = ov_in | wb_sum[WIDE_W];
            end
            MOP_STEP: ps_in = mul_r;
            default: ;
         endcase
      end

      if (cmd.add_offset) begin
         s_in  = off_sum[WIDE_W-1:0];
         ov_in = ov_in | off_sum[WIDE_W];
      end

      if (cmd.first_sample) begin
         pl_in = ps_ff;
         x_in  = x_ff + step_ext;
      end

      // the left term of this sample is the right term of the one before
      if (cmd.accum) begin
         left_in  = acc_l[WIDE_W-1:0];
         right_in = acc_r[WIDE_W-1:0];
         ov_in    = ov_in | acc_l[WIDE_W] | acc_r[WIDE_W];
         pl_in    = ps_ff;
         x_in     = x_ff + step_ext;
         idx_in   = idx_ff + COUNT_BITS'(1);
      end

      if (cmd.load_out) begin
         area_in = area_sum[WIDE_W:1];
         ovo_in  = ov_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cubic_ff     <= CUBIC_RESET;
         square_ff    <= '0;
         linear_ff    <= '0;
         offset_ff    <= '0;
         count_reg_ff <= SAMPLE_COUNT_RESET;
      end else begin
         cubic_ff     <= cubic_in;
         square_ff    <= square_in;
         linear_ff    <= linear_in;
         offset_ff    <= offset_in;
         count_reg_ff <= count_reg_in;
      end
      diff_ff  <= diff_in;
      count_ff <= count_in;
      idx_ff   <= idx_in;
      step_ff  <= step_in;
      x_ff     <= x_in;
      x2_ff    <= x2_in;
      x3_ff    <= x3_in;
      s_ff     <= s_in;
      ps_ff    <= ps_in;
      pl_ff    <= pl_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      area_ff  <= area_in;
      ov_ff    <= ov_in;
      ovo_ff   <= ovo_in;
   end

   always_comb begin
      status.count_zero  = (count_eff == '0);
      status.div_done    = div_done;
      status.mul_done    = mul_done;
      status.last_sample = (idx_ff == count_ff - COUNT_BITS'(1));
   end

   assign rsp_area     = area_ff;
   assign rsp_overflow = ovo_ff;

endmodule

// ===== src/cti_ctrl.sv =====
// Controller: sequences divide, polynomial products and sample updates.
// Depends on cti_pkg and the assertion macro header; drives cti_dp.
`include "cubic_trapezoid_integrator_top_macros.svh"

module cti_ctrl import cti_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   mul_op_type op_ff, op_in;
   logic       first_ff, first_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= MOP_XX;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.mul_op   = op_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               first_in = 1'b1;
               state_in = status.count_zero ? ST_DONE : ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               op_in    = MOP_XX;
               state_in = ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (status.mul_done) begin
               case (op_ff)
                  MOP_XX: begin
                     op_in    = MOP_X2X;
                     state_in = ST_MUL_GO;
                  end
                  MOP_X2X: begin
                     op_in    = MOP_C3;
                     state_in = ST_MUL_GO;
                  end
                  MOP_C3: begin
                     op_in    = MOP_C2;
                     state_in = ST_MUL_GO;
                  end
                  MOP_C2: begin
                     op_in    = MOP_C1;
                     state_in = ST_MUL_GO;
                  end
                  MOP_C1:   state_in = ST_OFFSET;
                  MOP_STEP: state_in = ST_SAMPLE;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_OFFSET: begin
            cmd.add_offset = 1'b1;
            op_in          = MOP_STEP;
            state_in       = ST_MUL_GO;
         end
         ST_SAMPLE: begin
            op_in    = MOP_XX;
            first_in = 1'b0;
            if (first_ff) begin
               // f(lower) * step only primes the left term
               cmd.first_sample = 1'b1;
               state_in         = ST_MUL_GO;
            end else begin
               cmd.accum = 1'b1;
               state_in  = status.last_sample ? ST_DONE : ST_MUL_GO;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `CTI_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready, "result word overwritten before taken")
   `CTI_ASSERT_NOW(a_div_done_awaited, clock, reset, status.div_done, state_ff == ST_DIV_WAIT, "divider done outside divide wait")
   `CTI_ASSERT_NOW(a_mul_done_awaited, clock, reset, status.mul_done, state_ff == ST_MUL_WAIT, "multiplier done outside multiply wait")
   `CTI_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff == ST_DIV_GO || state_ff == ST_DONE, "accepted word did not start work")

endmodule

// ===== src/cubic_trapezoid_integrator_top.sv =====
// Cubic trapezoidal integrator: takes a Q16.16 interval word and returns a
// saturated Q48.16 area word with an overflow flag. Each word is processed
// alone. The step division yields one quotient bit a cycle; then come
// sample_count + 1 polynomial evaluations, each with six 64x64 products run
// through one 32x32 multiplier, plus an offset add and a sample update. A
// zero count goes straight to the answer with no division or products.
// A finished word sits in the output register while the next interval
// is accepted. Depends on cti_pkg, cti_ctrl and cti_dp.
module cubic_trapezoid_integrator_top import cti_pkg::*; #(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_interval_low,
   input  logic signed [DATA_W-1:0] req_interval_high,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WIDE_W-1:0] rsp_area,
   output logic                     rsp_overflow,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_W-1:0]    csr_addr,
   input  logic [DATA_W-1:0]        csr_wdata
);

   cmd_type    cmd;
   status_type status;

   cti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cti_dp #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_interval_low  (req_interval_low),
      .req_interval_high (req_interval_high),
      .cmd               (cmd),
      .status            (status),
      .rsp_area          (rsp_area),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

// ===== verif/cubic_trapezoid_integrator_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for cubic_trapezoid_integrator_top: sends interval words, predicts each area
// word with a fixed-point trapezoid model of its own and checks the results in order.
// Depends on cti_pkg and the integrator RTL.
module cubic_trapezoid_integrator_top_tb;
   import cti_pkg::*;

   localparam int COUNT_BITS = 16;
   localparam int FRAC_BITS = 16;
   localparam int Q_ONE = 1 << FRAC_BITS;
   localparam longint STEP_MAX = 64'sd2147483647;
   localparam longint STEP_MIN = -64'sd2147483648;
   // allow a wide margin over the slowest legal run
   localparam int CYCLE_LIMIT = 6_000_000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic signed [WIDE_W-1:0] area;
      logic                     overflow;
   } area_word_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_interval_low = '0;
   logic signed [DATA_W-1:0] req_interval_high = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [WIDE_W-1:0] rsp_area;
   logic                     rsp_overflow;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_addr = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;

   // register shadow used by the predictor
   logic signed [DATA_W-1:0] cubic_q = CUBIC_RESET;
   logic signed [DATA_W-1:0] square_q = '0;
   logic signed [DATA_W-1:0] linear_q = '0;
   logic signed [DATA_W-1:0] offset_q = '0;
   logic [CNT_REG_W-1:0]     count_q = SAMPLE_COUNT_RESET;

   area_word_t pending_areas[$];
   int         mismatch_count = 0;
   int         cycle_count = 0;
   bit         no_idle = 1'b0;

   cubic_trapezoid_integrator_top #(
      .COUNT_BITS(COUNT_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_interval_low(req_interval_low),
      .req_interval_high(req_interval_high),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_area(rsp_area),
      .rsp_overflow(rsp_overflow),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------- prediction ----------------

   // Q-format product: magnitude shifted toward zero, saturated to 64 bits
   function automatic longint mul_q(input longint a, input longint b, inout bit ovf);
      logic [63:0]  ua, ub, m, limit;
      logic [127:0] prod;
      bit           neg;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      prod = {64'd0, ua} * {64'd0, ub};
      prod = prod >> FRAC_BITS;
      limit = neg ? WIDE_MIN : WIDE_MAX;
      if (prod > {64'd0, limit}) begin
         prod = {64'd0, limit};
         ovf = 1'b1;
      end
      m = prod[63:0];
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint add_sat(input longint a, input longint b, inout bit ovf);
      longint s;
      s = a + b;
      if ((a < 0) == (b < 0) && (s < 0) != (a < 0)) begin
         ovf = 1'b1;
         return (a < 0) ? longint'(WIDE_MIN) : longint'(WIDE_MAX);
      end
      return s;
   endfunction

   function automatic longint eval_cubic(input longint x, inout bit ovf);
      longint x2, x3, s;
      x2 = mul_q(x, x, ovf);
      x3 = mul_q(x2, x, ovf);
      s = mul_q(longint'(cubic_q), x3, ovf);
      s = add_sat(s, mul_q(longint'(square_q), x2, ovf), ovf);
      s = add_sat(s, mul_q(longint'(linear_q), x, ovf), ovf);
      return add_sat(s, longint'(offset_q), ovf);
   endfunction

   function automatic area_word_t integrate_cubic(input logic signed [DATA_W-1:0] low,
                                                  input logic signed [DATA_W-1:0] high);
      longint                 lo, hi, n, step, prev, next, left, right;
      logic signed [WIDE_W:0] total;
      bit                     ovf;
      area_word_t             r;
      lo = low;
      hi = high;
      n = count_q & ((64'd1 << COUNT_BITS) - 1);
      ovf = 1'b0;
      left = 0;
      right = 0;
      r.area = '0;
      r.overflow = 1'b0;
      if (n == 0) return r;
      step = (hi - lo) / n;
      if (step > STEP_MAX) begin
         step = STEP_MAX;
         ovf = 1'b1;
      end
      if (step < STEP_MIN) begin
         step = STEP_MIN;
         ovf = 1'b1;
      end
      prev = eval_cubic(lo, ovf);
      for (longint i = 1; i <= n; i++) begin
         next = eval_cubic(lo + i * step, ovf);
         left = add_sat(left, mul_q(prev, step, ovf), ovf);
         right = add_sat(right, mul_q(next, step, ovf), ovf);
         prev = next;
      end
      // exact floor of the mean
      total = {left[63], left} + {right[63], right};
      r.area = total[WIDE_W:1];
      r.overflow = ovf;
      return r;
   endfunction

   // ---------------- drivers ----------------

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (addr)
         REG_COEFF_CUBIC:  cubic_q = data;
         REG_COEFF_SQUARE: square_q = data;
         REG_COEFF_LINEAR: linear_q = data;
         REG_COEFF_OFFSET: offset_q = data;
         REG_SAMPLE_COUNT: count_q = data[CNT_REG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_areas.size() != 0);
   endtask

   task automatic set_config(input logic [DATA_W-1:0] c3, input logic [DATA_W-1:0] c2,
                             input logic [DATA_W-1:0] c1, input logic [DATA_W-1:0] c0,
                             input logic [DATA_W-1:0] count_word);
      wait_idle();
      write_reg(REG_COEFF_CUBIC, c3);
      write_reg(REG_COEFF_SQUARE, c2);
      write_reg(REG_COEFF_LINEAR, c1);
      write_reg(REG_COEFF_OFFSET, c0);
      write_reg(REG_SAMPLE_COUNT, count_word);
   endtask

   task automatic send_interval(input logic signed [DATA_W-1:0] low,
                                input logic signed [DATA_W-1:0] high);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_interval_low <= low;
      req_interval_high <= high;
      do @(posedge clock); while (!req_ready);
      pending_areas.push_back(integrate_cubic(low, high));
   endtask

   // ---------------- result checking ----------------

   initial begin
      area_word_t exp_word;
      int         stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            // hold off until a word is offered, then keep it waiting
            rsp_ready <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_areas.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected area word: area %0d overflow %0b", rsp_area, rsp_overflow);
         end else begin
            exp_word = pending_areas.pop_front();
            if (rsp_area !== exp_word.area || rsp_overflow !== exp_word.overflow) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("area mismatch: expected area %0d overflow %0b, got area %0d overflow %0b",
                           exp_word.area, exp_word.overflow, rsp_area, rsp_overflow);
            end
         end
      end
   end

   // ---------------- random values ----------------

   function automatic logic [DATA_W-1:0] rand_coeff();
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: return NARROW_MAX;
         2: return NARROW_MIN;
         3: return '0;
         default: return $urandom_range(0, 8 * Q_ONE) - 4 * Q_ONE;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] rand_bound();
      if ($urandom_range(0, 3) == 0) return $urandom();
      return $urandom_range(0, 32 * Q_ONE) - 16 * Q_ONE;
   endfunction

   // ---------------- tests ----------------

   task automatic test_reset_config();
      // cubic 1.0 over 8192 steps straight out of reset
      send_interval(-(3 * Q_ONE / 2), 2 * Q_ONE);
   endtask

   task automatic test_zero_count();
      set_config(Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0);
      send_interval(NARROW_MIN, NARROW_MAX);
      send_interval(NARROW_MAX, NARROW_MIN);
      send_interval(0, 0);
   endtask

   task automatic test_single_step();
      set_config(Q_ONE, -2 * Q_ONE, Q_ONE / 2, 3 * Q_ONE, 1);
      send_interval(NARROW_MIN, NARROW_MAX);   // step saturates high
      send_interval(NARROW_MAX, NARROW_MIN);   // step saturates low
      send_interval(0, Q_ONE);
      send_interval(-1, 1);
   endtask

   task automatic test_coeff_extremes();
      set_config(NARROW_MAX, NARROW_MAX, NARROW_MAX, NARROW_MAX, 3);
      send_interval(-Q_ONE, Q_ONE);
      send_interval(-256 * Q_ONE, 256 * Q_ONE);
      set_config(NARROW_MIN, NARROW_MIN, NARROW_MIN, NARROW_MIN, 4);
      send_interval(-Q_ONE, 2 * Q_ONE);
      send_interval(NARROW_MIN, NARROW_MAX);
   endtask

   task automatic test_reversed_bounds();
      set_config(-Q_ONE / 4, Q_ONE, -3 * Q_ONE, Q_ONE / 8, 5);
      send_interval(3 * Q_ONE, -2 * Q_ONE);
      send_interval(Q_ONE, Q_ONE);
      send_interval(-Q_ONE, -3 * Q_ONE);
   endtask

   task automatic test_unmapped_index();
      wait_idle();
      for (int a = int'(REG_SAMPLE_COUNT) + 1; a < (1 << CSR_ADDR_W); a++)
         write_reg(CSR_ADDR_W'(a), $urandom());
      send_interval(-Q_ONE, 2 * Q_ONE);
      send_interval(1, 7);
   endtask

   task automatic test_random_phases();
      logic [DATA_W-1:0]    junk;
      logic [CNT_REG_W-1:0] cnt;
      int                   pick;
      for (int phase = 0; phase < 8; phase++) begin
         pick = $urandom_range(0, 19);
         if (pick < 2) cnt = 0;
         else if (pick < 5) cnt = $urandom_range(13, 256);
         else cnt = $urandom_range(1, 12);
         junk = $urandom();
         // upper bits of the count write are don't-care
         set_config(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(), {junk[31:16], cnt});
         no_idle = (phase % 4 == 3);
         for (int k = 0; k < 12; k++) begin
            if ($urandom_range(0, 15) == 0) wait_idle();
            send_interval(rand_bound(), rand_bound());
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_config();
      test_zero_count();
      test_single_step();
      test_coeff_extremes();
      test_reversed_bounds();
      test_unmapped_index();
      test_random_phases();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_areas.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
